>>> src/gts_pkg.sv
// Shared types, character codes and token/scanner codes for the GraphQL token scanner.
package gts_pkg;

    // Document size limit; offsets saturate at the smaller of this and the field range.
    localparam int unsigned MAX_DOC_BYTES = 65535;
    localparam int unsigned POS_FIELD_MAX = 65535;
    localparam int unsigned POS_LIMIT_INT =
        (MAX_DOC_BYTES < POS_FIELD_MAX) ? MAX_DOC_BYTES : POS_FIELD_MAX;

    localparam int POS_W  = 16;
    localparam int LEN_W  = 16;
    localparam int KIND_W = 3;

    localparam logic [POS_W-1:0] POS_LIMIT = POS_LIMIT_INT[POS_W-1:0];
    localparam logic [LEN_W-1:0] LEN_MAX   = {LEN_W{1'b1}};
    localparam logic [LEN_W-1:0] DOTS_MAX  = 16'd3;

    // Queue between front and back, and the result buffer.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int OUT_DEPTH   = 4;
    localparam int OPTR_W      = $clog2(OUT_DEPTH);

    // Token kinds.
    localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NAME   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PUNCT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_COMMA  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_INT    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FLOAT  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_STRING = 3'd6;

    // Character codes.
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Character classes decided by the front end.
    typedef struct packed {
        logic alpha;
        logic digit;
        logic punct;
        logic dot;
        logic comma;
        logic minus;
        logic plus;
        logic zero;
        logic exp_mark;
        logic quote;
        logic bslash;
    } char_class_t;

    // One classified byte as it sits in the queue.
    typedef struct packed {
        char_class_t      cls;
        logic [POS_W-1:0] pos;
        logic             ovf;
        logic             last;
    } item_t;

    // One token record.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  start;
        logic [LEN_W-1:0]  len;
        logic              doc_end;
        logic              ovf;
    } rec_t;

    // Queue status seen by the producer and the consumer.
    typedef struct packed {
        logic full;
        logic valid;
    } queue_stat_t;

    function automatic rec_t make_rec(input logic [KIND_W-1:0] kind,
                                      input logic [POS_W-1:0] start,
                                      input logic [LEN_W-1:0] len,
                                      input logic ovf);
        rec_t r;
        r.kind    = kind;
        r.start   = start;
        r.len     = len;
        r.doc_end = 1'b0;
        r.ovf     = ovf;
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
        return (v == LEN_MAX) ? v : v + LEN_W'(1);
    endfunction

endpackage

>>> src/gts_front.sv
// Front end: accepts document bytes, classifies them and tracks position and overflow.
module gts_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_char_byte,
    input  logic                  s_doc_last,
    input  gts_pkg::queue_stat_t  q_stat,
    output logic                  q_push,
    output gts_pkg::item_t        q_item
);

    logic [gts_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                      ovf_reg, ovf_next;
    logic                      at_limit;
    logic                      accept;
    gts_pkg::char_class_t      cls;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;

    always_comb begin
        cls.alpha    = (s_char_byte inside {[gts_pkg::CH_UP_A:gts_pkg::CH_UP_Z],
                                            [gts_pkg::CH_LOW_A:gts_pkg::CH_LOW_Z],
                                            gts_pkg::CH_UNDER});
        cls.digit    = (s_char_byte inside {[gts_pkg::CH_ZERO:gts_pkg::CH_NINE]});
        cls.punct    = (s_char_byte inside {gts_pkg::CH_COMMA, gts_pkg::CH_DOT,
                                            gts_pkg::CH_BANG, gts_pkg::CH_DOLLAR,
                                            gts_pkg::CH_LPAREN, gts_pkg::CH_RPAREN,
                                            gts_pkg::CH_COLON, gts_pkg::CH_EQUAL,
                                            gts_pkg::CH_AT, gts_pkg::CH_LBRACK,
                                            gts_pkg::CH_RBRACK, gts_pkg::CH_LBRACE,
                                            gts_pkg::CH_PIPE, gts_pkg::CH_RBRACE});
        cls.dot      = (s_char_byte == gts_pkg::CH_DOT);
        cls.comma    = (s_char_byte == gts_pkg::CH_COMMA);
        cls.minus    = (s_char_byte == gts_pkg::CH_MINUS);
        cls.plus     = (s_char_byte == gts_pkg::CH_PLUS);
        cls.zero     = (s_char_byte == gts_pkg::CH_ZERO);
        cls.exp_mark = (s_char_byte inside {gts_pkg::CH_LOW_E, gts_pkg::CH_UP_E});
        cls.quote    = (s_char_byte == gts_pkg::CH_QUOTE);
        cls.bslash   = (s_char_byte == gts_pkg::CH_BSLASH);
    end

    // Offsets saturate at the limit; from there on the overflow flag sticks.
    assign at_limit = (pos_reg >= gts_pkg::POS_LIMIT);

    always_comb begin
        q_item.cls  = cls;
        q_item.pos  = at_limit ? gts_pkg::POS_LIMIT : pos_reg;
        q_item.ovf  = ovf_reg || at_limit;
        q_item.last = s_doc_last;
    end

    always_comb begin
        pos_next = pos_reg;
        ovf_next = ovf_reg;
        if (accept) begin
            if (s_doc_last) begin
                pos_next = '0;
                ovf_next = 1'b0;
            end else begin
                ovf_next = q_item.ovf;
                pos_next = at_limit ? gts_pkg::POS_LIMIT
                                    : pos_reg + gts_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            ovf_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

>>> src/gts_queue.sv
// Small queue of classified bytes between the front end and the token engine.
module gts_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  gts_pkg::item_t        push_item,
    input  logic                  pop,
    output gts_pkg::item_t        head_item,
    output gts_pkg::queue_stat_t  stat
);

    gts_pkg::item_t                mem_reg [gts_pkg::QUEUE_DEPTH];
    logic [gts_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [gts_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [gts_pkg::QPTR_W:0]      count_reg, count_next;

    assign stat.full  = (count_reg == (gts_pkg::QPTR_W+1)'(gts_pkg::QUEUE_DEPTH));
    assign stat.valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + gts_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + gts_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (gts_pkg::QPTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (gts_pkg::QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/gts_back.sv
// Token engine: applies the lexer state update to each queued byte and buffers the records.
module gts_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    input  gts_pkg::item_t                    q_item,
    output logic                              q_pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [gts_pkg::KIND_W-1:0]        m_token_kind,
    output logic [gts_pkg::POS_W-1:0]         m_start_offset,
    output logic [gts_pkg::LEN_W-1:0]         m_token_length,
    output logic                              m_doc_end,
    output logic                              m_overflow
);

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_NAME = 3'd1;
    localparam logic [2:0] MODE_DOTS = 3'd2;
    localparam logic [2:0] MODE_NUM  = 3'd3;
    localparam logic [2:0] MODE_STR  = 3'd4;

    localparam logic [2:0] PH_DIGITS  = 3'd0;
    localparam logic [2:0] PH_SIGN    = 3'd1;
    localparam logic [2:0] PH_ZERO    = 3'd2;
    localparam logic [2:0] PH_FRAC    = 3'd3;
    localparam logic [2:0] PH_EXP     = 3'd4;
    localparam logic [2:0] PH_EXPSIGN = 3'd5;
    localparam logic [2:0] PH_EXPNUM  = 3'd6;

    localparam int CNT_W = gts_pkg::OPTR_W + 1;

    logic [2:0]                  mode_reg, mode_next;
    logic [2:0]                  phase_reg, phase_next;
    logic [gts_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [gts_pkg::POS_W-1:0]   start_reg, start_next;
    logic [gts_pkg::LEN_W-1:0]   len_reg, len_next;
    logic                        bs_reg, bs_next;

    gts_pkg::rec_t               rec_a, rec_b;
    logic [1:0]                  n_rec;

    gts_pkg::rec_t               buf_reg [gts_pkg::OUT_DEPTH];
    logic [gts_pkg::OPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [gts_pkg::OPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        room;
    logic                        m_take;
    gts_pkg::rec_t               head;

    // A byte is taken only when the buffer can hold the two records it may produce.
    assign room   = (count_reg <= CNT_W'(gts_pkg::OUT_DEPTH - 2));
    assign q_pop  = q_valid && room;
    assign m_take = m_valid && m_ready;

    always_comb begin
        gts_pkg::char_class_t c;
        logic                 takes;
        gts_pkg::rec_t        r;

        c          = q_item.cls;
        takes      = 1'b0;
        r          = '0;
        mode_next  = mode_reg;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        start_next = start_reg;
        len_next   = len_reg;
        bs_next    = bs_reg;
        rec_a      = '0;
        rec_b      = '0;
        n_rec      = 2'd0;

        case (mode_reg)
            MODE_NAME: begin
                takes = c.alpha || c.digit;
            end
            MODE_DOTS: begin
                takes = c.dot && (len_reg < gts_pkg::DOTS_MAX);
            end
            MODE_NUM: begin
                case (phase_reg)
                    PH_SIGN: begin
                        if (c.digit) begin
                            takes      = 1'b1;
                            phase_next = c.zero ? PH_ZERO : PH_DIGITS;
                        end
                    end
                    PH_DIGITS, PH_ZERO: begin
                        if (c.digit && phase_reg == PH_DIGITS) begin
                            takes = 1'b1;
                        end else if (c.dot) begin
                            takes      = 1'b1;
                            kind_next  = gts_pkg::KIND_FLOAT;
                            phase_next = PH_FRAC;
                        end else if (c.exp_mark) begin
                            takes      = 1'b1;
                            kind_next  = gts_pkg::KIND_FLOAT;
                            phase_next = PH_EXP;
                        end
                    end
                    PH_FRAC: begin
                        if (c.digit) begin
                            takes = 1'b1;
                        end else if (c.exp_mark) begin
                            takes      = 1'b1;
                            phase_next = PH_EXP;
                        end
                    end
                    PH_EXP: begin
                        if (c.plus || c.minus) begin
                            takes      = 1'b1;
                            phase_next = PH_EXPSIGN;
                        end else if (c.digit) begin
                            takes      = 1'b1;
                            phase_next = PH_EXPNUM;
                        end
                    end
                    PH_EXPSIGN, PH_EXPNUM: begin
                        if (c.digit) begin
                            takes      = 1'b1;
                            phase_next = PH_EXPNUM;
                        end
                    end
                    default: begin
                        takes = 1'b0;
                    end
                endcase
            end
            MODE_STR: begin
                takes    = 1'b1;
                len_next = gts_pkg::sat_inc(len_reg);
                if (c.quote && !bs_reg) begin
                    rec_a     = gts_pkg::make_rec(kind_reg, start_reg, len_next, q_item.ovf);
                    n_rec     = 2'd1;
                    mode_next = MODE_IDLE;
                end else begin
                    bs_next = c.bslash && !bs_reg;
                end
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase

        // Name, dots and number tokens either grow or close here.
        if (mode_next != MODE_IDLE && mode_next != MODE_STR) begin
            if (takes) begin
                len_next = gts_pkg::sat_inc(len_reg);
            end else begin
                rec_a     = gts_pkg::make_rec(kind_next, start_reg, len_reg, q_item.ovf);
                n_rec     = 2'd1;
                mode_next = MODE_IDLE;
            end
        end

        // A byte the open token refused may start the next token.
        if (!takes) begin
            start_next = q_item.pos;
            len_next   = gts_pkg::LEN_W'(1);
            if (c.alpha) begin
                mode_next = MODE_NAME;
                kind_next = gts_pkg::KIND_NAME;
            end else if (c.digit || c.minus) begin
                mode_next  = MODE_NUM;
                kind_next  = gts_pkg::KIND_INT;
                phase_next = c.minus ? PH_SIGN : (c.zero ? PH_ZERO : PH_DIGITS);
            end else if (c.quote) begin
                mode_next = MODE_STR;
                kind_next = gts_pkg::KIND_STRING;
                bs_next   = 1'b0;
            end else if (c.dot) begin
                mode_next = MODE_DOTS;
                kind_next = gts_pkg::KIND_PUNCT;
            end else if (c.punct) begin
                kind_next = c.comma ? gts_pkg::KIND_COMMA : gts_pkg::KIND_PUNCT;
                r = gts_pkg::make_rec(kind_next, q_item.pos, gts_pkg::LEN_W'(1), q_item.ovf);
                if (n_rec == 2'd0) begin
                    rec_a = r;
                end else begin
                    rec_b = r;
                end
                n_rec     = n_rec + 2'd1;
                mode_next = MODE_IDLE;
            end
        end

        // End of document: flush, guarantee one record, mark it and clear the state.
        if (q_item.last) begin
            if (mode_next != MODE_IDLE) begin
                r = gts_pkg::make_rec(kind_next, start_next, len_next, q_item.ovf);
                if (n_rec == 2'd0) begin
                    rec_a = r;
                end else begin
                    rec_b = r;
                end
                n_rec = n_rec + 2'd1;
            end
            if (n_rec == 2'd0) begin
                rec_a = gts_pkg::make_rec(gts_pkg::KIND_NONE, '0, '0, q_item.ovf);
                n_rec = 2'd1;
            end
            if (n_rec == 2'd1) begin
                rec_a.doc_end = 1'b1;
            end else begin
                rec_b.doc_end = 1'b1;
            end
            mode_next  = MODE_IDLE;
            phase_next = PH_DIGITS;
            kind_next  = gts_pkg::KIND_NONE;
            start_next = '0;
            len_next   = '0;
            bs_next    = 1'b0;
        end
    end

    // Result buffer: up to two writes per cycle, one read.
    assign head           = buf_reg[rd_ptr_reg];
    assign m_valid        = (count_reg != '0);
    assign m_token_kind   = head.kind;
    assign m_start_offset = head.start;
    assign m_token_length = head.len;
    assign m_doc_end      = head.doc_end;
    assign m_overflow     = head.ovf;

    always_comb begin
        logic [CNT_W-1:0] n_push;
        n_push      = q_pop ? CNT_W'(n_rec) : '0;
        wr_ptr_next = wr_ptr_reg + gts_pkg::OPTR_W'(n_push);
        rd_ptr_next = m_take ? rd_ptr_reg + gts_pkg::OPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + n_push - (m_take ? CNT_W'(1) : CNT_W'(0));
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            if (n_rec != 2'd0) begin
                buf_reg[wr_ptr_reg] <= rec_a;
            end
            if (n_rec == 2'd2) begin
                buf_reg[wr_ptr_reg + gts_pkg::OPTR_W'(1)] <= rec_b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            phase_reg  <= PH_DIGITS;
            kind_reg   <= gts_pkg::KIND_NONE;
            start_reg  <= '0;
            len_reg    <= '0;
            bs_reg     <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (q_pop) begin
                mode_reg  <= mode_next;
                phase_reg <= phase_next;
                kind_reg  <= kind_next;
                start_reg <= start_next;
                len_reg   <= len_next;
                bs_reg    <= bs_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(gts_pkg::OUT_DEPTH))
        else $error("result buffer count out of range");

    a_last_has_record: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_item.last) |-> (n_rec != 2'd0))
        else $error("final byte produced no record");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_item.last) |=> (mode_reg == MODE_IDLE && len_reg == '0))
        else $error("scanner state not cleared after document end");

    a_dots_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_DOTS) |-> (len_reg != '0 && len_reg <= gts_pkg::DOTS_MAX))
        else $error("dot run length out of range");
`endif

endmodule

>>> src/graphql_token_scanner.sv
// Top level of the GraphQL token scanner: front end, byte queue and token engine.
//
// The scanner takes a GraphQL document one byte per transaction on the s_ channel
// and returns one token record per transaction on the m_ channel: kind (name,
// punctuator, comma, int, float, string), start offset and length. A byte that
// closes a token is looked at again as the start of the next one, so one byte can
// yield two records; on the byte marked s_doc_last any open token is flushed, the
// last record of the document carries m_doc_end (a record of kind none with zero
// offset and length is sent when nothing else closes there), and the scanner
// starts the next document from offset zero. Offsets saturate at 65535 and set
// the sticky m_overflow flag for the rest of the document; lengths saturate too.
// Throughput is one byte per clock while neither buffer holds it back: the front
// end classifies a byte and tracks its offset in the cycle it is accepted, a
// four-entry queue carries it to the token engine, which applies the whole state
// update combinationally and writes its records into a four-entry result buffer.
// The engine takes a byte only when the buffer has two free entries, and the
// buffer drains one record per clock while m_ready is high, so a stream in which
// many bytes close two tokens runs at the rate of the m_ channel, one record per
// clock. A byte is registered in the queue and its records in the result buffer.
module graphql_token_scanner (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_char_byte,
    input  logic                             s_doc_last,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [gts_pkg::KIND_W-1:0]       m_token_kind,
    output logic [gts_pkg::POS_W-1:0]        m_start_offset,
    output logic [gts_pkg::LEN_W-1:0]        m_token_length,
    output logic                             m_doc_end,
    output logic                             m_overflow
);

    // Front end to queue.
    logic                  q_push;
    gts_pkg::item_t        q_in_item;
    gts_pkg::queue_stat_t  q_stat;

    // Queue to token engine.
    logic                  q_pop;
    gts_pkg::item_t        q_head;

    gts_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_byte (s_char_byte),
        .s_doc_last  (s_doc_last),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_item      (q_in_item)
    );

    gts_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .pop       (q_pop),
        .head_item (q_head),
        .stat      (q_stat)
    );

    // The engine sees the queue head whenever the queue holds a byte.
    gts_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_stat.valid),
        .q_item         (q_head),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_start_offset (m_start_offset),
        .m_token_length (m_token_length),
        .m_doc_end      (m_doc_end),
        .m_overflow     (m_overflow)
    );

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the GraphQL token scanner: random documents, own predictor.
module tb_top;

    // Whole-run watchdog.
    localparam int CYCLE_LIMIT = 1_000_000;

    // Scanner modes and number sub-states of the predictor.
    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_NAME, SCAN_DOTS, SCAN_NUM, SCAN_STR
    } scan_mode_t;

    typedef enum logic [2:0] {
        NUM_INT, NUM_SIGN, NUM_ZERO, NUM_FRAC, NUM_EXP, NUM_EXP_SIGN, NUM_EXP_DIGITS
    } num_phase_t;

    // Which side of the bench inserts bubbles during the current phase.
    typedef enum logic [1:0] {
        IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
    } idle_mode_t;

    // One document byte waiting to be sent.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } doc_byte_t;

    logic                         aclk;
    logic                         aresetn        = 1'b0;
    logic                         s_valid        = 1'b0;
    logic                         s_ready;
    logic [7:0]                   s_char_byte    = 8'h00;
    logic                         s_doc_last     = 1'b0;
    logic                         m_valid;
    logic                         m_ready        = 1'b0;
    logic [gts_pkg::KIND_W-1:0]   m_token_kind;
    logic [gts_pkg::POS_W-1:0]    m_start_offset;
    logic [gts_pkg::LEN_W-1:0]    m_token_length;
    logic                         m_doc_end;
    logic                         m_overflow;

    doc_byte_t      byte_queue[$];       // bytes not yet offered to the scanner
    gts_pkg::rec_t  expected_tokens[$];  // predicted token records, oldest first
    idle_mode_t     idle_mode = IDLE_NONE;

    int fail_count      = 0;
    int cycle_count     = 0;
    int token_bytes     = 0;
    int docs_queued     = 0;
    int bytes_accepted  = 0;
    int records_checked = 0;
    int ovf_records     = 0;

    // Predictor state: a private copy of the scanner's token tracking.
    scan_mode_t  sc_mode;
    num_phase_t  sc_phase;
    logic [2:0]  sc_kind;
    logic [15:0] sc_start;
    logic [15:0] sc_len;
    logic [15:0] sc_pos;
    logic        sc_escape;
    logic        sc_ovf;

    // Records produced by the byte being predicted; a byte yields at most two.
    gts_pkg::rec_t step_recs[2];
    int            step_count;

    graphql_token_scanner i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_byte    (s_char_byte),
        .s_doc_last     (s_doc_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_start_offset (m_start_offset),
        .m_token_length (m_token_length),
        .m_doc_end      (m_doc_end),
        .m_overflow     (m_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Character classes.
    // ------------------------------------------------------------------

    function automatic bit is_digit_ch(input logic [7:0] c);
        return c >= gts_pkg::CH_ZERO && c <= gts_pkg::CH_NINE;
    endfunction

    // Letters and underscore may start a name.
    function automatic bit is_name_start(input logic [7:0] c);
        return (c >= gts_pkg::CH_UP_A && c <= gts_pkg::CH_UP_Z) ||
               (c >= gts_pkg::CH_LOW_A && c <= gts_pkg::CH_LOW_Z) ||
               c == gts_pkg::CH_UNDER;
    endfunction

    function automatic bit is_punct_ch(input logic [7:0] c);
        case (c)
            gts_pkg::CH_COMMA, gts_pkg::CH_DOT, gts_pkg::CH_BANG, gts_pkg::CH_DOLLAR,
            gts_pkg::CH_LPAREN, gts_pkg::CH_RPAREN, gts_pkg::CH_COLON,
            gts_pkg::CH_EQUAL, gts_pkg::CH_AT, gts_pkg::CH_LBRACK,
            gts_pkg::CH_RBRACK, gts_pkg::CH_LBRACE, gts_pkg::CH_PIPE,
            gts_pkg::CH_RBRACE: begin
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Token predictor.
    // ------------------------------------------------------------------

    // Back to the state of a fresh document.
    function automatic void clear_scanner();
        sc_mode   = SCAN_IDLE;
        sc_phase  = NUM_INT;
        sc_kind   = gts_pkg::KIND_NONE;
        sc_start  = '0;
        sc_len    = '0;
        sc_pos    = '0;
        sc_escape = 1'b0;
        sc_ovf    = 1'b0;
    endfunction

    // Records carry the overflow flag as it stands when they are produced.
    function automatic void post_token(input logic [2:0] kind, input logic [15:0] start,
                                       input logic [15:0] len);
        gts_pkg::rec_t r;
        if (step_count >= 2) begin
            return;
        end
        r.kind    = kind;
        r.start   = start;
        r.len     = len;
        r.doc_end = 1'b0;
        r.ovf     = sc_ovf;
        step_recs[step_count] = r;
        step_count++;
    endfunction

    function automatic void close_token();
        post_token(sc_kind, sc_start, sc_len);
        sc_mode = SCAN_IDLE;
    endfunction

    // Lengths saturate rather than wrap.
    function automatic void lengthen();
        if (sc_len != gts_pkg::LEN_MAX) begin
            sc_len++;
        end
    endfunction

    // A byte not taken by the open token may start a new one. Single-byte
    // punctuators (everything but the dot) are complete at once.
    function automatic void open_token(input logic [7:0] c, input logic [15:0] pos);
        sc_start = pos;
        sc_len   = 16'd1;
        if (is_name_start(c)) begin
            sc_mode = SCAN_NAME;
            sc_kind = gts_pkg::KIND_NAME;
        end else if (is_digit_ch(c) || c == gts_pkg::CH_MINUS) begin
            sc_mode = SCAN_NUM;
            sc_kind = gts_pkg::KIND_INT;
            if (c == gts_pkg::CH_MINUS) begin
                sc_phase = NUM_SIGN;
            end else if (c == gts_pkg::CH_ZERO) begin
                sc_phase = NUM_ZERO;
            end else begin
                sc_phase = NUM_INT;
            end
        end else if (c == gts_pkg::CH_QUOTE) begin
            sc_mode   = SCAN_STR;
            sc_kind   = gts_pkg::KIND_STRING;
            sc_escape = 1'b0;
        end else if (c == gts_pkg::CH_DOT) begin
            sc_mode = SCAN_DOTS;
            sc_kind = gts_pkg::KIND_PUNCT;
        end else if (is_punct_ch(c)) begin
            sc_kind = (c == gts_pkg::CH_COMMA) ? gts_pkg::KIND_COMMA : gts_pkg::KIND_PUNCT;
            post_token(sc_kind, pos, 16'd1);
            sc_mode = SCAN_IDLE;
        end
    endfunction

    // Number grammar: returns 1 when the open number takes the byte.
    function automatic bit consume_number_byte(input logic [7:0] c);
        bit dig;
        bit ex;
        dig = is_digit_ch(c);
        ex  = (c == gts_pkg::CH_LOW_E) || (c == gts_pkg::CH_UP_E);
        case (sc_phase)
            NUM_SIGN: begin
                if (!dig) begin
                    return 1'b0;
                end
                sc_phase = (c == gts_pkg::CH_ZERO) ? NUM_ZERO : NUM_INT;
                return 1'b1;
            end
            NUM_INT, NUM_ZERO: begin
                if (dig && sc_phase == NUM_INT) begin
                    return 1'b1;
                end
                if (c == gts_pkg::CH_DOT) begin
                    sc_kind  = gts_pkg::KIND_FLOAT;
                    sc_phase = NUM_FRAC;
                    return 1'b1;
                end
                if (ex) begin
                    sc_kind  = gts_pkg::KIND_FLOAT;
                    sc_phase = NUM_EXP;
                    return 1'b1;
                end
                return 1'b0;
            end
            NUM_FRAC: begin
                if (dig) begin
                    return 1'b1;
                end
                if (ex) begin
                    sc_phase = NUM_EXP;
                    return 1'b1;
                end
                return 1'b0;
            end
            NUM_EXP: begin
                if (c == gts_pkg::CH_PLUS || c == gts_pkg::CH_MINUS) begin
                    sc_phase = NUM_EXP_SIGN;
                    return 1'b1;
                end
                if (dig) begin
                    sc_phase = NUM_EXP_DIGITS;
                    return 1'b1;
                end
                return 1'b0;
            end
            NUM_EXP_SIGN, NUM_EXP_DIGITS: begin
                if (dig) begin
                    sc_phase = NUM_EXP_DIGITS;
                    return 1'b1;
                end
                return 1'b0;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    // Advances the predictor by one accepted byte and queues the records it closes.
    function automatic void predict_byte(input logic [7:0] c, input logic last);
        logic [15:0] pos;
        bit          takes;
        step_count = 0;
        takes      = 1'b0;

        // Offsets stop at the limit; any byte found there marks the document.
        if (sc_pos >= gts_pkg::POS_LIMIT) begin
            sc_ovf = 1'b1;
            sc_pos = gts_pkg::POS_LIMIT;
        end
        pos = sc_pos;
        if (sc_pos < gts_pkg::POS_LIMIT) begin
            sc_pos++;
        end

        case (sc_mode)
            SCAN_NAME: begin
                takes = is_name_start(c) || is_digit_ch(c);
            end
            SCAN_DOTS: begin
                takes = (c == gts_pkg::CH_DOT) && (sc_len < gts_pkg::DOTS_MAX);
            end
            SCAN_NUM: begin
                takes = consume_number_byte(c);
            end
            SCAN_STR: begin
                // A string takes every byte; the closing quote counts in its length.
                takes = 1'b1;
                lengthen();
                if (c == gts_pkg::CH_QUOTE && !sc_escape) begin
                    close_token();
                end else begin
                    sc_escape = (c == gts_pkg::CH_BSLASH) && !sc_escape;
                end
            end
            default: begin
                sc_mode = SCAN_IDLE;
            end
        endcase

        if (sc_mode != SCAN_IDLE && sc_mode != SCAN_STR) begin
            if (takes) begin
                lengthen();
            end else begin
                close_token();
            end
        end
        // The byte that closed a token gets a second look as a starter.
        if (!takes) begin
            open_token(c, pos);
        end

        if (last) begin
            if (sc_mode != SCAN_IDLE) begin
                close_token();
            end
            if (step_count == 0) begin
                post_token(gts_pkg::KIND_NONE, 16'd0, 16'd0);
            end
            step_recs[step_count - 1].doc_end = 1'b1;
            clear_scanner();
        end

        for (int i = 0; i < step_count; i++) begin
            expected_tokens.push_back(step_recs[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Document generation.
    // ------------------------------------------------------------------

    task automatic add_byte(input logic [7:0] c);
        byte_queue.push_back(doc_byte_t'{c, 1'b0});
    endtask

    // Token bytes count toward the size of a random phase; filler does not.
    task automatic add_tok(input logic [7:0] c);
        add_byte(c);
        token_bytes++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_tok(s[i]);
        end
    endtask

    // Flags the most recently queued byte as the end of its document.
    task automatic close_doc();
        byte_queue[byte_queue.size() - 1].last = 1'b1;
        docs_queued++;
    endtask

    function automatic logic [7:0] rand_digit();
        return gts_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_name_char();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) begin
            return gts_pkg::CH_LOW_A + 8'(r);
        end else if (r < 52) begin
            return gts_pkg::CH_UP_A + 8'(r - 26);
        end
        return gts_pkg::CH_UNDER;
    endfunction

    function automatic logic [7:0] rand_punct();
        case ($urandom_range(0, 13))
            0:       return gts_pkg::CH_COMMA;
            1:       return gts_pkg::CH_DOT;
            2:       return gts_pkg::CH_BANG;
            3:       return gts_pkg::CH_DOLLAR;
            4:       return gts_pkg::CH_LPAREN;
            5:       return gts_pkg::CH_RPAREN;
            6:       return gts_pkg::CH_COLON;
            7:       return gts_pkg::CH_EQUAL;
            8:       return gts_pkg::CH_AT;
            9:       return gts_pkg::CH_LBRACK;
            10:      return gts_pkg::CH_RBRACK;
            11:      return gts_pkg::CH_LBRACE;
            12:      return gts_pkg::CH_PIPE;
            default: return gts_pkg::CH_RBRACE;
        endcase
    endfunction

    task automatic add_digits(input int n);
        repeat (n) add_tok(rand_digit());
    endtask

    task automatic add_exponent();
        add_tok($urandom_range(0, 1) ? gts_pkg::CH_LOW_E : gts_pkg::CH_UP_E);
        if ($urandom_range(0, 1)) begin
            add_tok($urandom_range(0, 1) ? gts_pkg::CH_PLUS : gts_pkg::CH_MINUS);
        end
        add_digits($urandom_range(1, 2));
    endtask

    // One token, mostly well formed, sometimes cut short or replaced by noise.
    task automatic add_random_token();
        int n;
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1: begin
                add_tok(rand_name_char());
                n = $urandom_range(0, 6);
                repeat (n) add_tok($urandom_range(0, 3) == 0 ? rand_digit() : rand_name_char());
            end
            2: begin
                add_tok(rand_punct());
            end
            3: begin
                if ($urandom_range(0, 1)) begin
                    add_tok(gts_pkg::CH_MINUS);
                end
                add_digits($urandom_range(1, 5));
            end
            4: begin
                if ($urandom_range(0, 1)) begin
                    add_tok(gts_pkg::CH_MINUS);
                end
                add_digits($urandom_range(1, 3));
                add_tok(gts_pkg::CH_DOT);
                add_digits($urandom_range(1, 3));
                if ($urandom_range(0, 1)) begin
                    add_exponent();
                end
            end
            5: begin
                // Leading zero straight into an exponent.
                if ($urandom_range(0, 1)) begin
                    add_tok(gts_pkg::CH_MINUS);
                end
                add_tok(gts_pkg::CH_ZERO);
                add_exponent();
            end
            6: begin
                add_tok(gts_pkg::CH_QUOTE);
                n = $urandom_range(0, 8);
                repeat (n) begin
                    if ($urandom_range(0, 4) == 0) begin
                        add_tok(gts_pkg::CH_BSLASH);
                        case ($urandom_range(0, 2))
                            0:       add_tok(gts_pkg::CH_QUOTE);
                            1:       add_tok(gts_pkg::CH_BSLASH);
                            default: add_tok(gts_pkg::CH_LOW_A + 8'd13);
                        endcase
                    end else begin
                        c = 8'($urandom_range(8'h20, 8'hFF));
                        add_tok((c == gts_pkg::CH_QUOTE || c == gts_pkg::CH_BSLASH)
                                ? gts_pkg::CH_LOW_A : c);
                    end
                end
                // Now and then the string is left open.
                if ($urandom_range(0, 7) != 0) begin
                    add_tok(gts_pkg::CH_QUOTE);
                end
            end
            7: begin
                // Numbers that stop in the middle of their grammar.
                case ($urandom_range(0, 4))
                    0: add_tok(gts_pkg::CH_MINUS);
                    1: begin
                        add_tok(rand_digit());
                        add_tok(gts_pkg::CH_LOW_E);
                    end
                    2: begin
                        add_tok(gts_pkg::CH_ZERO);
                        add_tok(gts_pkg::CH_DOT);
                    end
                    3: begin
                        add_tok(rand_digit());
                        add_tok(gts_pkg::CH_UP_E);
                        add_tok(gts_pkg::CH_PLUS);
                    end
                    default: begin
                        add_tok(gts_pkg::CH_ZERO);
                        add_tok(gts_pkg::CH_ZERO);
                    end
                endcase
            end
            8: begin
                n = $urandom_range(1, 5);
                repeat (n) add_tok(gts_pkg::CH_DOT);
            end
            default: begin
                n = $urandom_range(1, 3);
                repeat (n) add_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Half the time tokens abut, so closing bytes are also starters.
    task automatic add_random_gap();
        case ($urandom_range(0, 5))
            3:       add_byte(8'h20);
            4:       add_byte(8'h0A);
            5:       add_byte(8'h09);
            default: ;
        endcase
    endtask

    task automatic queue_random_docs(input int target);
        int first;
        int ntok;
        first = token_bytes;
        while (token_bytes - first < target) begin
            ntok = $urandom_range(1, 8);
            repeat (ntok) begin
                add_random_token();
                add_random_gap();
            end
            close_doc();
        end
    endtask

    // Holds the sender back until the scanner has returned every predicted record.
    task automatic wait_drained();
        do begin
            @(posedge aclk);
        end while (byte_queue.size() != 0 || s_valid || expected_tokens.size() != 0);
    endtask

    function automatic bit sender_pauses();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 70;
            IDLE_BOTH:   return $urandom_range(0, 99) < 14;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 70;
            IDLE_BOTH:     return $urandom_range(0, 99) < 14;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte driver. A transaction completes on an edge where s_valid and s_ready
    // are both high; the predictor advances right there. A new byte is only
    // loaded once the current one has gone, so valid never drops early.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_bytes
        doc_byte_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_byte(s_char_byte, s_doc_last);
                bytes_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (byte_queue.size() != 0 && !sender_pauses()) begin
                    nxt = byte_queue.pop_front();
                    s_valid     <= 1'b1;
                    s_char_byte <= nxt.ch;
                    s_doc_last  <= nxt.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Token monitor. Every record transaction is matched against the oldest
    // prediction; a record with nothing predicted is an error of its own.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_tokens
        gts_pkg::rec_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("unexpected token record: kind %0d start %0d length %0d",
                           m_token_kind, m_start_offset, m_token_length);
                    fail_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    check_field("token_kind", want.kind, m_token_kind);
                    check_field("start_offset", want.start, m_start_offset);
                    check_field("token_length", want.len, m_token_length);
                    check_field("doc_end", want.doc_end, m_doc_end);
                    check_field("overflow", want.ovf, m_overflow);
                    records_checked++;
                    if (m_overflow) begin
                        ovf_records++;
                    end
                end
            end
            m_ready <= !receiver_stalls();
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d records still expected",
                     cycle_count, expected_tokens.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence. Each phase is fed, then fully drained before the next
    // one changes the idling pattern.
    // ------------------------------------------------------------------
    initial begin
        clear_scanner();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed document: name with digit, a run of four dots (three plus
        // one), comma, a lone minus closed by a letter, a NUL skipped, a float
        // built from a leading zero and an exponent, a bang, and a string with
        // an escaped quote and an escaped backslash that ends the document.
        idle_mode = IDLE_NONE;
        add_text("_9....,-a");
        add_byte(8'h00);
        add_text("0e+1!");
        add_tok(gts_pkg::CH_QUOTE);
        add_tok(gts_pkg::CH_BSLASH);
        add_tok(gts_pkg::CH_QUOTE);
        add_tok(gts_pkg::CH_BSLASH);
        add_tok(gts_pkg::CH_BSLASH);
        add_tok(gts_pkg::CH_QUOTE);
        close_doc();
        // A document of one skipped byte: only the empty end record comes back.
        add_byte(8'hFF);
        close_doc();
        // A leading zero closed by a letter; the name is flushed at the end.
        add_text("0x");
        close_doc();

        queue_random_docs(140);
        wait_drained();

        idle_mode = IDLE_SENDER;
        queue_random_docs(140);
        wait_drained();

        idle_mode = IDLE_RECEIVER;
        queue_random_docs(140);
        wait_drained();

        idle_mode = IDLE_BOTH;
        queue_random_docs(140);
        wait_drained();

        // Give any stray record time to show up.
        repeat (16) @(posedge aclk);

        $display("Fed %0d bytes in %0d documents under four idling patterns;",
                 bytes_accepted, docs_queued);
        $display("checked %0d token records, %0d of them with the overflow flag set.",
                 records_checked, ovf_records);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
